### design/hsfd_pkg.sv
package hsfd_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BUSY      = 2'd2,
        STATUS_CRC_ERROR = 2'd3
    } status_t;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned RAW_W     = 20;
    localparam int unsigned HUM_C_W   = 14;
    localparam int unsigned TEMP_C_W  = 15;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned GEN_W     = 2;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    localparam logic [GEN_W-1:0] GEN_FIRST  = 2'd1;
    localparam logic [GEN_W-1:0] GEN_SECOND = 2'd2;
    localparam logic [GEN_W-1:0] GEN_RESET  = GEN_SECOND;

    localparam logic [IDX_W-1:0] LAST_IDX_SHORT = 3'd5;
    localparam logic [IDX_W-1:0] LAST_IDX_LONG  = 3'd6;

    // register index taken from paddr[2]
    localparam logic REG_SENSOR_GENERATION = 1'b0;

    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
            begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/hsfd_convert.sv
module hsfd_convert (
    input  logic [hsfd_pkg::RAW_W-1:0]    raw_hum,
    input  logic [hsfd_pkg::RAW_W-1:0]    raw_temp,
    output logic [hsfd_pkg::HUM_C_W-1:0]  hum_centi,
    output logic [hsfd_pkg::TEMP_C_W-1:0] temp_centi
);
    import hsfd_pkg::*;

    logic [RAW_W+13:0] hum_prod;
    logic [RAW_W+14:0] temp_prod;
    logic [TEMP_C_W-1:0] temp_scaled;

    assign hum_prod    = {14'd0, raw_hum} * {{RAW_W{1'b0}}, HUM_SCALE};
    assign temp_prod   = {15'd0, raw_temp} * {{RAW_W{1'b0}}, TEMP_SCALE};
    assign hum_centi   = hum_prod[RAW_W+13:RAW_W];
    assign temp_scaled = temp_prod[RAW_W+14:RAW_W];
    // two's complement wrap gives the signed result
    assign temp_centi  = temp_scaled - TEMP_OFFSET;

endmodule

### design/humidity_sensor_frame_decoder_core.sv
// result: a result appears in the output register in the cycle after its byte is accepted
// throughput: one byte per cycle; a byte is taken while a result waits, if that result
//   is taken in the same cycle
// reset: byte count zero, crc 0xff, generation 2 (seven-byte frames), no result pending
module humidity_sensor_frame_decoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsfd_pkg::ADDR_W-1:0]         paddr,
    input  logic [hsfd_pkg::DATA_W-1:0]         pwdata,
    output logic [hsfd_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hsfd_pkg::BYTE_W-1:0]         byte_value,
    input  logic                                frame_start,
    input  logic                                bus_error,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [hsfd_pkg::RAW_W-1:0]          raw_humidity,
    output logic [hsfd_pkg::RAW_W-1:0]          raw_temperature,
    output logic [hsfd_pkg::HUM_C_W-1:0]        humidity_centi,
    output logic signed [hsfd_pkg::TEMP_C_W-1:0] temperature_centi
);
    import hsfd_pkg::*;

    logic [GEN_W-1:0]    gen_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]   stat_byte_reg, stat_byte_next;
    logic [RAW_W-1:0]    hum_acc_reg, hum_acc_next;
    logic [RAW_W-1:0]    temp_acc_reg, temp_acc_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [RAW_W-1:0]    raw_hum_reg, raw_temp_reg;
    logic [HUM_C_W-1:0]  hum_c_reg;
    logic [TEMP_C_W-1:0] temp_c_reg;

    logic                in_acc;
    logic                res_valid;
    logic [IDX_W-1:0]    cur_idx;
    logic [IDX_W-1:0]    last_idx;
    logic                ok_frame;
    logic [BYTE_W-1:0]   crc_step;
    logic [HUM_C_W-1:0]  hum_c;
    logic [TEMP_C_W-1:0] temp_c;
    logic                cfg_wr;

    assign pready   = 1'b1;
    assign prdata   = {{(DATA_W-GEN_W){1'b0}}, gen_reg};
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SENSOR_GENERATION);

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;
    assign last_idx = (gen_reg == GEN_FIRST) ? LAST_IDX_SHORT : LAST_IDX_LONG;
    assign cur_idx  = frame_start ? '0 : idx_reg;
    assign crc_step = crc8_byte((cur_idx == '0) ? CRC_INIT : crc_reg, byte_value);

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        stat_byte_next = stat_byte_reg;
        hum_acc_next   = hum_acc_reg;
        temp_acc_next  = temp_acc_reg;
        res_valid      = 1'b0;
        status_next    = STATUS_SHORT;
        if (bus_error)
        begin
            idx_next  = '0;
            res_valid = 1'b1;
        end
        else
        begin
            res_valid = frame_start && (idx_reg != '0);
            unique case (cur_idx)
                3'd0:
                begin
                    stat_byte_next = byte_value;
                    crc_next       = crc_step;
                end
                3'd1:
                begin
                    hum_acc_next = {byte_value, 12'd0};
                    crc_next     = crc_step;
                end
                3'd2:
                begin
                    hum_acc_next = hum_acc_reg | {8'd0, byte_value, 4'd0};
                    crc_next     = crc_step;
                end
                3'd3:
                begin
                    hum_acc_next  = hum_acc_reg | {16'd0, byte_value[7:4]};
                    temp_acc_next = {byte_value[3:0], 16'd0};
                    crc_next      = crc_step;
                end
                3'd4:
                begin
                    temp_acc_next = temp_acc_reg | {4'd0, byte_value, 8'd0};
                    crc_next      = crc_step;
                end
                3'd5:
                begin
                    temp_acc_next = temp_acc_reg | {12'd0, byte_value};
                    crc_next      = crc_step;
                end
                default:
                begin
                end
            endcase
            if (cur_idx >= last_idx)
            begin
                idx_next  = '0;
                res_valid = 1'b1;
                priority if (stat_byte_next[BYTE_W-1])
                begin
                    status_next = STATUS_BUSY;
                end
                else if (gen_reg == GEN_SECOND && cur_idx == LAST_IDX_LONG
                         && crc_reg != byte_value)
                begin
                    status_next = STATUS_CRC_ERROR;
                end
                else
                begin
                    status_next = STATUS_OK;
                end
            end
            else
            begin
                idx_next = cur_idx + 3'd1;
            end
        end
    end

    assign ok_frame = (status_next == STATUS_OK);

    hsfd_convert u_convert (
        .raw_hum    (hum_acc_next),
        .raw_temp   (temp_acc_next),
        .hum_centi  (hum_c),
        .temp_centi (temp_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= GEN_RESET;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            stat_byte_reg <= '0;
            hum_acc_reg   <= '0;
            temp_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                gen_reg <= pwdata[GEN_W-1:0];
            end
            if (in_acc)
            begin
                idx_reg       <= idx_next;
                crc_reg       <= crc_next;
                stat_byte_reg <= stat_byte_next;
                hum_acc_reg   <= hum_acc_next;
                temp_acc_reg  <= temp_acc_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_acc && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && res_valid)
        begin
            status_reg   <= status_next;
            raw_hum_reg  <= ok_frame ? hum_acc_next : '0;
            raw_temp_reg <= ok_frame ? temp_acc_next : '0;
            hum_c_reg    <= ok_frame ? hum_c : '0;
            temp_c_reg   <= ok_frame ? temp_c : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign raw_humidity      = raw_hum_reg;
    assign raw_temperature   = raw_temp_reg;
    assign humidity_centi    = hum_c_reg;
    assign temperature_centi = temp_c_reg;

endmodule

### dv/humidity_sensor_frame_decoder_core_test.sv
module humidity_sensor_frame_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hsfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 155;
    localparam logic [GEN_W-1:0] GEN_UNCHECKED_LO = 2'd0;
    localparam logic [GEN_W-1:0] GEN_UNCHECKED_HI = 2'd3;

    typedef struct packed {
        status_t                     st;
        logic [RAW_W-1:0]            rh;
        logic [RAW_W-1:0]            rt;
        logic [HUM_C_W-1:0]          hc;
        logic signed [TEMP_C_W-1:0]  tc;
    } reading_t;

    // msb-first crc-8, no final xor
    function automatic logic [7:0] crc_next(logic [7:0] acc, logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    class frame_tracker;
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] idx;
        logic [7:0]       crc;
        logic [7:0]       head;
        logic [RAW_W-1:0] hum;
        logic [RAW_W-1:0] temp;
        reading_t         due[$];
        int               errors;

        function new();
            gen = GEN_RESET;
            idx = '0;
            crc = CRC_INIT;
            head = '0;
            hum = '0;
            temp = '0;
            errors = 0;
        endfunction

        function void set_generation(logic [GEN_W-1:0] g);
            gen = g;
        endfunction

        function void post(status_t st);
            reading_t r;
            logic [63:0] p;
            r = '0;
            r.st = st;
            if (st == STATUS_OK)
            begin
                r.rh = hum;
                r.rt = temp;
                p = 64'(hum) * 64'd10000;
                r.hc = HUM_C_W'(p >> 20);
                p = 64'(temp) * 64'd20000;
                r.tc = TEMP_C_W'((p >> 20) - 64'd5000);
            end
            due.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic start, logic err);
            logic [IDX_W-1:0] at;
            logic [IDX_W-1:0] last;
            status_t st;
            if (err)
            begin
                idx = '0;
                post(STATUS_SHORT);
                return;
            end
            if (start)
            begin
                if (idx != 0)
                begin
                    post(STATUS_SHORT);
                end
                idx = '0;
            end
            at = idx;
            case (at)
                3'd0:
                begin
                    head = b;
                    crc = crc_next(CRC_INIT, b);
                end
                3'd1: hum = {b, 12'h000};
                3'd2: hum = hum | {8'h00, b, 4'h0};
                3'd3:
                begin
                    hum = hum | {16'h0000, b[7:4]};
                    temp = {b[3:0], 16'h0000};
                end
                3'd4: temp = temp | {4'h0, b, 8'h00};
                3'd5: temp = temp | {12'h000, b};
                default: ;
            endcase
            if (at >= 3'd1 && at <= 3'd5)
            begin
                crc = crc_next(crc, b);
            end
            last = (gen == GEN_FIRST) ? LAST_IDX_SHORT : LAST_IDX_LONG;
            if (at >= last)
            begin
                idx = '0;
                if (head[7])
                begin
                    st = STATUS_BUSY;
                end
                else if (gen == GEN_SECOND && at == LAST_IDX_LONG && crc != b)
                begin
                    st = STATUS_CRC_ERROR;
                end
                else
                begin
                    st = STATUS_OK;
                end
                post(st);
            end
            else
            begin
                idx = at + 3'd1;
            end
        endfunction

        function void match_reading(reading_t got);
            reading_t want;
            if (due.size() == 0)
            begin
                $error("result with nothing pending, status %0d", got.st);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.st != want.st)
            begin
                $error("status: expected %0d, got %0d", want.st, got.st);
                errors++;
            end
            if (got.rh != want.rh)
            begin
                $error("raw_humidity: expected %0d, got %0d", want.rh, got.rh);
                errors++;
            end
            if (got.rt != want.rt)
            begin
                $error("raw_temperature: expected %0d, got %0d", want.rt, got.rt);
                errors++;
            end
            if (got.hc != want.hc)
            begin
                $error("humidity_centi: expected %0d, got %0d", want.hc, got.hc);
                errors++;
            end
            if (got.tc != want.tc)
            begin
                $error("temperature_centi: expected %0d, got %0d", want.tc, got.tc);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_ready;
    logic [BYTE_W-1:0]           byte_value;
    logic                        frame_start;
    logic                        bus_error;
    logic                        out_valid;
    logic                        out_ready;
    logic [1:0]                  status;
    logic [RAW_W-1:0]            raw_humidity;
    logic [RAW_W-1:0]            raw_temperature;
    logic [HUM_C_W-1:0]          humidity_centi;
    logic signed [TEMP_C_W-1:0]  temperature_centi;

    frame_tracker book = new();
    int sent = 0;
    int cycles = 0;
    bit calm = 1'b0;

    humidity_sensor_frame_decoder_core dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_item(logic [7:0] b, logic start, logic err);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_value <= b;
        frame_start <= start;
        bus_error <= err;
        do @(posedge clk); while (in_ready !== 1'b1);
        book.take_byte(b, start, err);
        sent++;
    endtask

    // body holds bytes 0..5, byte 0 in the top bits; byte 6 is the crc
    task automatic send_frame(logic [47:0] body, int len, bit crc_ok, bit mark);
        logic [7:0] c;
        logic [7:0] b;
        c = CRC_INIT;
        for (int k = 0; k < 6; k++)
        begin
            c = crc_next(c, body[47 - 8*k -: 8]);
        end
        for (int k = 0; k < len; k++)
        begin
            if (k < 6)
            begin
                b = body[47 - 8*k -: 8];
            end
            else
            begin
                b = crc_ok ? c : c ^ 8'($urandom_range(1, 255));
            end
            send_item(b, mark && k == 0, 1'b0);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (book.due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_generation(logic [GEN_W-1:0] g);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_SENSOR_GENERATION, 2'b00};
        pwdata <= DATA_W'(g);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        book.set_generation(g);
    endtask

    task automatic random_burst();
        int pick;
        int len;
        logic [47:0] body;
        len = (book.gen == GEN_FIRST) ? 6 : 7;
        pick = $urandom_range(0, 99);
        body = {16'($urandom), $urandom};
        if ($urandom_range(0, 9) == 0)
        begin
            body[39:0] = $urandom_range(0, 1) ? '0 : '1;
        end
        if ($urandom_range(0, 4) != 0)
        begin
            body[47] = 1'b0;
        end
        if (pick < 75)
        begin
            send_frame(body, len, $urandom_range(0, 6) != 0, $urandom_range(0, 9) != 0);
        end
        else if (pick < 85)
        begin
            send_frame(body, $urandom_range(1, len - 1), 1'b1, 1'b1);
        end
        else if (pick < 92)
        begin
            send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_item(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial
    begin
        logic [GEN_W-1:0] plan [10];
        int quota;
        plan = '{GEN_FIRST, GEN_UNCHECKED_HI, GEN_SECOND, GEN_UNCHECKED_LO, GEN_FIRST,
                 GEN_SECOND, GEN_UNCHECKED_HI, GEN_FIRST, GEN_UNCHECKED_LO, GEN_SECOND};
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        byte_value <= '0;
        frame_start <= 1'b0;
        bus_error <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale readings with a good crc
        send_frame(48'h1C_FF_FF_FF_FF_FF, 7, 1'b1, 1'b1);
        // bus error with no frame open
        send_item(8'h00, 1'b0, 1'b1);
        // bus error beats a restart mid-frame
        send_frame(48'h05_12_34_56_78_9A, 2, 1'b1, 1'b1);
        send_item(8'hA5, 1'b1, 1'b1);
        // restart abandons a frame, then zero frame with bad crc
        send_frame(48'h7F_00_00_00_00_00, 1, 1'b1, 1'b1);
        send_frame(48'h00_00_00_00_00_00, 7, 1'b0, 1'b1);
        // busy wins over a bad crc
        send_frame(48'h80_AB_CD_EF_01_23, 7, 1'b0, 1'b1);
        settle();

        foreach (plan[p])
        begin
            write_generation(plan[p]);
            calm = ($urandom_range(0, 3) == 0);
            quota = sent + PHASE_ITEMS;
            while (sent < quota)
            begin
                random_burst();
            end
            // may leave a frame open across the generation change (six bytes complete a generation-1 frame)
            if ($urandom_range(0, 1) == 1)
            begin
                send_frame({16'($urandom), $urandom}, $urandom_range(1, 6), 1'b1, 1'b1);
            end
            settle();
        end

        if (book.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        int stall;
        reading_t got;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pause_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            got.st = status_t'(status);
            got.rh = raw_humidity;
            got.rt = raw_temperature;
            got.hc = humidity_centi;
            got.tc = temperature_centi;
            book.match_reading(got);
        end
    end

endmodule

### humidity_sensor_frame_decoder_core.f
design/hsfd_pkg.sv
design/hsfd_convert.sv
design/humidity_sensor_frame_decoder_core.sv
dv/humidity_sensor_frame_decoder_core_test.sv
